// File: rtl/rahm_pkg.sv
`timescale 1ns / 1ps
package rahm_pkg;

	// Geometry
	localparam int REGIONS            = 4;
	localparam int ENTRIES_PER_REGION = 1024;
	localparam int TABLE_DEPTH        = REGIONS * ENTRIES_PER_REGION;
	localparam int ADDR_W             = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IDX_W              = $clog2(ENTRIES_PER_REGION);
	localparam int LIM_W              = IDX_W + 1;
	localparam int CAP_BYTES          = 4 * ENTRIES_PER_REGION;
	localparam int REG_W              = (REGIONS > 1) ? $clog2(REGIONS) : 1;

	// Field widths
	localparam int HANDLE_W = 32;
	localparam int BASE_W   = 32;
	localparam int SIZE_W   = 13;
	localparam int RUN_W    = 11;
	localparam int END_W    = ((IDX_W > RUN_W) ? IDX_W : RUN_W) + 1;

	// Configuration register map
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_BASE0  = 0;
	localparam int CFG_SIZE0  = 4;

	// Operation codes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_FILL   = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOREGION = 2'd1,
		ST_CLIPPED  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_FILL
	} state_t;

	typedef struct packed {
		logic              operation;
		logic [31:0]       address;
		logic [RUN_W-1:0]  run_length;
		logic [31:0]       new_handle;
	} req_t;

	typedef struct packed {
		logic [31:0] handle;
		status_t     status;
	} rsp_t;

	typedef struct packed {
		logic [REGIONS-1:0][BASE_W-1:0] base;
		logic [REGIONS-1:0][SIZE_W-1:0] size;
	} regions_t;

	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] origin;
		logic [IDX_W-1:0]  idx;
		logic [LIM_W-1:0]  limit;
	} match_t;

endpackage

// File: rtl/rahm_ram.sv
`timescale 1ns / 1ps
module rahm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/rahm_match.sv
`timescale 1ns / 1ps
module rahm_match (
	input  logic [31:0]        address,
	input  rahm_pkg::regions_t regions,
	output rahm_pkg::match_t   match
);
	import rahm_pkg::*;

	// Lowest-numbered region wins: scan from the top so region 0 is applied last.
	always_comb begin
		logic [32:0] diff;
		logic [31:0] span;
		match = '0;
		diff  = '0;
		span  = '0;
		for (int r = REGIONS - 1; r >= 0; r--) begin
			span = (32'(regions.size[r]) > 32'(CAP_BYTES)) ? 32'(CAP_BYTES)
			                                               : 32'(regions.size[r]);
			diff = {1'b0, address} - {1'b0, regions.base[r]};
			if (!diff[32] && (diff[31:0] < span)) begin
				match.hit    = 1'b1;
				match.origin = ADDR_W'(r * ENTRIES_PER_REGION);
				match.idx    = diff[IDX_W+1:2];
				match.limit  = LIM_W'((span + 32'd3) >> 2);
			end
		end
	end

endmodule

// File: rtl/region_address_handle_map_top.sv
`timescale 1ns / 1ps
// Region address to segment handle map.
// Input channel (in_valid/in_ready/in_data) takes one lookup or fill per transfer.
// Output channel (out_valid/out_ready/out_data) returns exactly one result per item.
// Config port (cfg_write/cfg_index/cfg_data) sets region bases (0..3) and byte sizes
// (4..7); write it only while the block is idle. Other indexes are dropped.
// Lookup: region match is combinational on the transfer; the table read is registered,
// then S_READ loads the result into the output register.
// Fill: one table entry written per cycle in S_FILL; the result is loaded with the last
// write. A fill of zero entries or a miss loads its result at the transfer itself.
// Items are handled one at a time: in_ready is high only in S_IDLE, so a new item is
// taken only once the last one has loaded its result.
// Reset: state, output valid and config registers clear at once, then a sweep zeroes the
// 4096-entry table, one entry per cycle with in_ready low; config writes are taken during it.
// Receiver stall: the result waits in the output register; in_ready stays low until
// that register is empty or being drained, so no result is ever dropped.
module region_address_handle_map_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  rahm_pkg::req_t                      in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output rahm_pkg::rsp_t                      out_data,
	input  logic                                cfg_write,
	input  logic [rahm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rahm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rahm_pkg::*;

	state_t            state_q, state_d;
	regions_t          regions_q;
	match_t            match;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] origin_q;
	logic [LIM_W-1:0]  ptr_q;
	logic [LIM_W-1:0]  end_q;
	logic [31:0]       handle_q;
	status_t           status_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic              accept;
	logic              clr_last;
	logic              fill_last;
	logic              fill_start;
	logic [END_W-1:0]  end_full;
	logic              clipped;
	logic [LIM_W-1:0]  end_w;
	logic [CFG_IDX_W-1:0] size_sel;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [31:0]       mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [31:0]       mem_rdata;
	logic              rsp_load;
	rsp_t              rsp_d;

	// Region match on the incoming address
	rahm_match u_match (
		.address (in_data.address),
		.regions (regions_q),
		.match   (match)
	);

	rahm_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign accept     = in_valid && in_ready;
	assign clr_last   = (clr_q == ADDR_W'(TABLE_DEPTH - 1));
	assign fill_last  = ((ptr_q + LIM_W'(1)) == end_q);
	assign fill_start = match.hit && (in_data.operation == OP_FILL)
	                    && (in_data.run_length != '0);

	// Clip the fill run at the end of the region
	assign end_full = END_W'(match.idx) + END_W'(in_data.run_length);
	assign clipped  = end_full > END_W'(match.limit);
	assign end_w    = clipped ? match.limit : LIM_W'(end_full);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept && match.hit) begin
					if (in_data.operation == OP_LOOKUP) begin
						state_d = S_READ;
					end else if (fill_start) begin
						state_d = S_FILL;
					end
				end
			end
			S_READ: state_d = S_IDLE;
			S_FILL: begin
				if (fill_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer: table port and result load
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = origin_q + ADDR_W'(ptr_q[IDX_W-1:0]);
		mem_wdata = handle_q;
		mem_raddr = match.origin + ADDR_W'(match.idx);
		rsp_load  = 1'b0;
		rsp_d     = '{handle: '0, status: ST_OK};
		unique case (state_q)
			S_CLEAR: begin
				// zero one entry per cycle
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (accept) begin
					if (!match.hit) begin
						rsp_load = 1'b1;
						rsp_d    = '{handle: '0, status: ST_NOREGION};
					end else if ((in_data.operation == OP_FILL) && !fill_start) begin
						// empty fill: nothing to write
						rsp_load = 1'b1;
					end
				end
			end
			S_READ: begin
				rsp_load = 1'b1;
				rsp_d    = '{handle: mem_rdata, status: ST_OK};
			end
			S_FILL: begin
				mem_we = 1'b1;
				if (fill_last) begin
					rsp_load = 1'b1;
					rsp_d    = '{handle: '0, status: status_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	// Capture the fill run at transfer; advance one entry per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			origin_q <= match.origin;
			ptr_q    <= LIM_W'(match.idx);
			end_q    <= end_w;
			handle_q <= in_data.new_handle;
			status_q <= clipped ? ST_CLIPPED : ST_OK;
		end else if (state_q == S_FILL) begin
			ptr_q <= ptr_q + LIM_W'(1);
		end
	end

	// Output register: hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			out_q <= rsp_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers; indexes past the map, or of absent regions, drop
	assign size_sel = cfg_index - CFG_IDX_W'(CFG_SIZE0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regions_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index < CFG_IDX_W'(CFG_BASE0 + REGIONS)) begin
				regions_q.base[cfg_index[REG_W-1:0]] <= cfg_data[BASE_W-1:0];
			end else if ((cfg_index >= CFG_IDX_W'(CFG_SIZE0))
			             && (cfg_index < CFG_IDX_W'(CFG_SIZE0 + REGIONS))) begin
				regions_q.size[size_sel[REG_W-1:0]] <= cfg_data[SIZE_W-1:0];
			end
		end
	end

endmodule
